// ----- design/mfb_pkg.sv -----
// ----------------------------------------------------------------------------
// mfb_pkg
// shared constants and codes for the max flow augmenting path unit
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int MAX_NODES_DEF = 128;
    localparam int NODE_IN_W     = 7;
    localparam int CAP_W         = 16;
    localparam int FLOW_W        = 17;
    localparam int WORD_W        = CAP_W + FLOW_W;
    localparam int RES_W         = 18;
    localparam int OUT_W         = 23;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_SOURCE     = 2'd1,
        CFG_SINK       = 2'd2
    } t_cfg_idx;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_SAME_END = 1'b1;

endpackage

// ----- design/mfb_ram.sv -----
// ----------------------------------------------------------------------------
// mfb_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module mfb_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [(1<<AW)];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/max_flow_bfs_augment_unit.sv -----
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_unit
// edmonds-karp max flow over an adjacency matrix store, one shared datapath
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  input     in   i_valid / o_stall     i_req_type i_edge_from i_edge_to i_edge_capacity
//  result    out  o_valid / i_stall     o_max_flow o_status
//  config    in   i_cfg_we              i_cfg_idx i_cfg_data
//
//  add edge word: writes the capacity at (from,to) and (to,from), one matrix write port
//  solve word: searches, each followed by a bottleneck walk and an augment on the path,
//  then the sink inflow sum, a clear of all 4^clog2(MAX_NODES) entries (16384 at default)
//  after reset the same store clear runs before the first word is taken
//  a finished result waits in the output register while i_stall is high
// ----------------------------------------------------------------------------
module max_flow_bfs_augment_unit #(
    parameter int MAX_NODES = mfb_pkg::MAX_NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [mfb_pkg::NODE_IN_W-1:0]    i_edge_from,
    input  logic [mfb_pkg::NODE_IN_W-1:0]    i_edge_to,
    input  logic [mfb_pkg::CAP_W-1:0]        i_edge_capacity,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mfb_pkg::OUT_W-1:0]        o_max_flow,
    output logic                             o_status,
    input  logic                             i_cfg_we,
    input  logic [mfb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mfb_pkg::NODE_IN_W-1:0]    i_cfg_data
);
    import mfb_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = 2 * NW;
    localparam int CW  = (NW > NODE_IN_W) ? NW : NODE_IN_W;
    localparam int ACW = NW + FLOW_W + 1;

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1 << 0,
        S_ADD2   = 19'd1 << 1,
        S_PCLR   = 19'd1 << 2,
        S_PSET   = 19'd1 << 3,
        S_QPOP   = 19'd1 << 4,
        S_QWT    = 19'd1 << 5,
        S_SCANRD = 19'd1 << 6,
        S_SCANEV = 19'd1 << 7,
        S_TP     = 19'd1 << 8,
        S_TM     = 19'd1 << 9,
        S_TE     = 19'd1 << 10,
        S_AP     = 19'd1 << 11,
        S_AR     = 19'd1 << 12,
        S_AW1    = 19'd1 << 13,
        S_AW2    = 19'd1 << 14,
        S_SRD    = 19'd1 << 15,
        S_SAC    = 19'd1 << 16,
        S_CLR    = 19'd1 << 17,
        S_DONE   = 19'd1 << 18
    } t_state;

    t_state r_state, n_state;

    logic [NODE_IN_W-1:0] r_node_count, r_source, r_sink;
    logic [NW-1:0]        r_from, r_to, n_from, n_to;
    logic [CAP_W-1:0]     r_cap, n_cap;
    logic [NW-1:0]        r_w, n_w, r_cur, n_cur, r_node, n_node, r_prev, n_prev;
    logic [NW-1:0]        r_head, n_head, r_tail, n_tail;
    logic                 r_found, n_found, r_emit, n_emit, r_stat, n_stat;
    logic signed [RES_W-1:0] r_add, n_add;
    logic signed [ACW-1:0]   r_acc, n_acc;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_flow, n_out_flow;
    logic                 r_out_stat, n_out_stat;

    logic [CW-1:0] nc_ext, n_eff;
    logic [NW-1:0] n_lim, src, dst;
    logic          from_ok, to_ok, src_ok, dst_ok, accept;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [WORD_W-1:0] s_wdata, s_rdata;
    logic [CAP_W-1:0]  s_cap;
    logic [FLOW_W-1:0] s_flow;
    logic signed [RES_W-1:0] res, flow_ext, flow_inc, flow_dec;

    logic          p_we, q_we;
    logic [NW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [NW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
    logic          take;

    assign nc_ext = CW'(r_node_count);
    assign n_eff  = (nc_ext > CW'(MAX_NODES - 1)) ? CW'(MAX_NODES - 1) : nc_ext;
    assign n_lim  = NW'(n_eff);
    assign src    = NW'(r_source);
    assign dst    = NW'(r_sink);

    assign from_ok = (i_edge_from != '0) && (CW'(i_edge_from) <= n_eff);
    assign to_ok   = (i_edge_to != '0) && (CW'(i_edge_to) <= n_eff);
    assign src_ok  = (r_source != '0) && (CW'(r_source) <= n_eff);
    assign dst_ok  = (r_sink != '0) && (CW'(r_sink) <= n_eff);

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    assign s_cap    = s_rdata[WORD_W-1 -: CAP_W];
    assign s_flow   = s_rdata[FLOW_W-1:0];
    assign flow_ext = RES_W'($signed(s_flow));
    assign res      = $signed({2'b00, s_cap}) - flow_ext;
    assign flow_inc = flow_ext + r_add;
    assign flow_dec = flow_ext - r_add;
    assign take     = (p_rdata == '0) && (res > 0);

    mfb_ram #(.DW(WORD_W), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    mfb_ram #(.DW(NW), .AW(NW)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    mfb_ram #(.DW(NW), .AW(NW)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_clr;
        s_wdata = '0;
        s_raddr = {r_cur, r_w};
        p_we    = 1'b0;
        p_waddr = r_w;
        p_wdata = '0;
        p_raddr = r_w;
        q_we    = 1'b0;
        q_waddr = r_tail;
        q_wdata = r_w;
        q_raddr = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == REQ_ADD && from_ok && to_ok) begin
                    s_we    = 1'b1;
                    s_waddr = {NW'(i_edge_from), NW'(i_edge_to)};
                    s_wdata = {i_edge_capacity, {FLOW_W{1'b0}}};
                end
            end
            S_ADD2: begin
                s_we    = 1'b1;
                s_waddr = {r_to, r_from};
                s_wdata = {r_cap, {FLOW_W{1'b0}}};
            end
            S_PCLR: begin
                p_we = 1'b1;
            end
            S_PSET: begin
                p_we    = 1'b1;
                p_waddr = src;
                p_wdata = src;
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = src;
            end
            S_SCANEV: begin
                p_we    = take;
                p_wdata = r_cur;
                q_we    = take;
            end
            S_TP, S_AP: begin
                p_raddr = r_node;
            end
            S_TM, S_AR: begin
                s_raddr = {p_rdata, r_node};
            end
            S_AW1: begin
                s_we    = 1'b1;
                s_waddr = {r_prev, r_node};
                s_wdata = {s_cap, flow_inc[FLOW_W-1:0]};
                s_raddr = {r_node, r_prev};
            end
            S_AW2: begin
                s_we    = 1'b1;
                s_waddr = {r_node, r_prev};
                s_wdata = {s_cap, flow_dec[FLOW_W-1:0]};
            end
            S_SRD: begin
                s_raddr = {r_w, dst};
            end
            S_CLR: begin
                s_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_from      = r_from;
        n_to        = r_to;
        n_cap       = r_cap;
        n_w         = r_w;
        n_cur       = r_cur;
        n_node      = r_node;
        n_prev      = r_prev;
        n_head      = r_head;
        n_tail      = r_tail;
        n_found     = r_found;
        n_emit      = r_emit;
        n_stat      = r_stat;
        n_add       = r_add;
        n_acc       = r_acc;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_stall;
        n_out_flow  = r_out_flow;
        n_out_stat  = r_out_stat;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_ADD) begin
                        n_from = NW'(i_edge_from);
                        n_to   = NW'(i_edge_to);
                        n_cap  = i_edge_capacity;
                        if (from_ok && to_ok) begin
                            n_state = S_ADD2;
                        end
                    end else begin
                        n_acc  = '0;
                        n_emit = 1'b1;
                        n_clr  = '0;
                        n_w    = NW'(1);
                        if (r_source == r_sink) begin
                            n_stat  = STAT_SAME_END;
                            n_state = S_CLR;
                        end else if (src_ok && dst_ok) begin
                            n_stat  = STAT_OK;
                            n_state = S_PCLR;
                        end else begin
                            n_stat  = STAT_OK;
                            n_state = S_CLR;
                        end
                    end
                end
            end
            S_ADD2: begin
                n_state = S_IDLE;
            end
            S_PCLR: begin
                if (r_w == n_lim) begin
                    n_state = S_PSET;
                end else begin
                    n_w = r_w + NW'(1);
                end
            end
            S_PSET: begin
                n_head  = '0;
                n_tail  = NW'(1);
                n_found = 1'b0;
                n_state = S_QPOP;
            end
            S_QPOP: begin
                if (r_tail > r_head && !r_found) begin
                    n_head  = r_head + NW'(1);
                    n_state = S_QWT;
                end else if (r_found) begin
                    n_node  = dst;
                    n_add   = {1'b0, {(RES_W-1){1'b1}}};
                    n_state = S_TP;
                end else begin
                    n_w     = NW'(1);
                    n_state = S_SRD;
                end
            end
            S_QWT: begin
                n_cur   = q_rdata;
                n_w     = NW'(1);
                n_state = S_SCANRD;
            end
            S_SCANRD: begin
                n_state = S_SCANEV;
            end
            S_SCANEV: begin
                if (take) begin
                    n_tail = r_tail + NW'(1);
                end
                if (take && r_w == dst) begin
                    n_found = 1'b1;
                    n_state = S_QPOP;
                end else if (r_w == n_lim) begin
                    n_state = S_QPOP;
                end else begin
                    n_w     = r_w + NW'(1);
                    n_state = S_SCANRD;
                end
            end
            S_TP: begin
                n_state = S_TM;
            end
            S_TM: begin
                n_prev  = p_rdata;
                n_state = S_TE;
            end
            S_TE: begin
                if (res < r_add) begin
                    n_add = res;
                end
                if (r_prev == src) begin
                    n_node  = dst;
                    n_state = S_AP;
                end else begin
                    n_node  = r_prev;
                    n_state = S_TP;
                end
            end
            S_AP: begin
                n_state = S_AR;
            end
            S_AR: begin
                n_prev  = p_rdata;
                n_state = S_AW1;
            end
            S_AW1: begin
                n_state = S_AW2;
            end
            S_AW2: begin
                n_node = r_prev;
                if (r_prev == src) begin
                    n_w     = NW'(1);
                    n_state = S_PCLR;
                end else begin
                    n_state = S_AP;
                end
            end
            S_SRD: begin
                n_state = S_SAC;
            end
            S_SAC: begin
                n_acc = r_acc + ACW'($signed(s_flow));
                if (r_w == n_lim) begin
                    n_clr   = '0;
                    n_state = S_CLR;
                end else begin
                    n_w     = r_w + NW'(1);
                    n_state = S_SRD;
                end
            end
            S_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = r_emit ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_flow  = (r_acc < 0) ? '0 : r_acc[OUT_W-1:0];
                    n_out_stat  = r_stat;
                    n_emit      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_emit       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_node_count <= NODE_IN_W'(1);
            r_source     <= NODE_IN_W'(1);
            r_sink       <= NODE_IN_W'(1);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    CFG_SOURCE:     r_source     <= i_cfg_data;
                    CFG_SINK:       r_sink       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_from     <= n_from;
        r_to       <= n_to;
        r_cap      <= n_cap;
        r_w        <= n_w;
        r_cur      <= n_cur;
        r_node     <= n_node;
        r_prev     <= n_prev;
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_found    <= n_found;
        r_stat     <= n_stat;
        r_add      <= n_add;
        r_acc      <= n_acc;
        r_out_flow <= n_out_flow;
        r_out_stat <= n_out_stat;
    end

    assign o_valid    = r_out_valid;
    assign o_max_flow = r_out_flow;
    assign o_status   = r_out_stat;

`ifndef ASSERT_OFF
    a_same_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_SAME_END |-> o_max_flow == '0)
        else $error("same end result carries nonzero flow");
    a_add_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_AW1 |-> r_add > 0)
        else $error("augment with nonpositive bottleneck");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCANEV |-> r_head <= r_tail)
        else $error("search queue head passed tail");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");
`endif
endmodule
